// ===== rtl/core/lsfx_pkg.sv =====
// Shared types, constants and lookup functions of the LED strip effect engine.
// Depends on nothing; imported by lsfx_div, lsfx_front, lsfx_back and the top level.
package lsfx_pkg;

  localparam int unsigned LenW = 7;
  localparam int unsigned IdxW = 6;
  localparam int unsigned ScW  = 9;
  localparam int unsigned DdW  = 10;
  localparam int unsigned DvW  = 8;

  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_ALL   = 3'd1;
  localparam logic [2:0] MODE_CHASE = 3'd2;
  localparam logic [2:0] MODE_FLASH = 3'd3;
  localparam logic [2:0] MODE_HEART = 3'd4;
  localparam logic [2:0] MODE_TRAIL = 3'd5;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_PIXELS = 2'd1;
  localparam logic [1:0] REG_FORE   = 2'd2;
  localparam logic [1:0] REG_BACK   = 2'd3;

  localparam logic [ScW-1:0] DEG_FULL = 9'd360;
  localparam logic [ScW-1:0] DEG_HALF = 9'd180;
  localparam logic [ScW-1:0] DEG_QTR  = 9'd90;
  localparam logic [ScW:0]   HB_STEP  = 10'd10;
  localparam logic [9:0]     LVL_MAX  = 10'd1023;

  typedef enum logic [2:0] {
    K_BLACK,
    K_FORE,
    K_CHASE,
    K_FLASH,
    K_HEART,
    K_TRAIL,
    K_NONE
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic            restart;
    logic [LenW-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] pixel_index;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            led_valid;
    logic [9:0]      led_level;
    logic            last;
  } res_t;

  localparam logic [7:0] GAMMA_LUT [16] = '{
    8'd0, 8'd1, 8'd2, 8'd6, 8'd12, 8'd20, 8'd31, 8'd44,
    8'd60, 8'd79, 8'd100, 8'd125, 8'd153, 8'd183, 8'd218, 8'd255
  };

  // 255 / gamma, entry 0 never used
  localparam logic [7:0] DIM_LUT [16] = '{
    8'd255, 8'd255, 8'd127, 8'd42, 8'd21, 8'd12, 8'd8, 8'd5,
    8'd4, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1
  };

  // smallest angle in degrees at which 15*sin reaches k
  localparam logic [6:0] DUTY_ANGLE [16] = '{
    7'd0, 7'd4, 7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd28,
    7'd33, 7'd37, 7'd42, 7'd48, 7'd54, 7'd61, 7'd69, 7'd90
  };

  function automatic logic [3:0] heart_duty(input logic [ScW-1:0] sc);
    logic [ScW-1:0] a;
    logic [3:0]     d;
    a = (sc >= DEG_FULL) ? sc - DEG_FULL : sc;
    d = '0;
    if (a != '0 && a < DEG_HALF) begin
      if (a > DEG_QTR) begin
        a = DEG_HALF - a;
      end
      for (int k = 1; k < 16; k++) begin
        if (a >= {2'b00, DUTY_ANGLE[k]}) begin
          d = 4'(k);
        end
      end
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/lsfx_fifo.sv =====
// Two-entry first-word-fall-through queue used for commands and results.
// Depends on nothing.
module lsfx_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_q, rd_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/lsfx_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lsfx_pkg for operand widths.
module lsfx_div import lsfx_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DdW-1:0] dividend_i,
  input  logic [DvW-1:0] divisor_i,
  output logic           done_o,
  output logic [DdW-1:0] quot_o,
  output logic [DvW-1:0] rem_o
);

  localparam logic [3:0] Steps = 4'(DdW);

  logic [DdW-1:0] quo_q;
  logic [DvW-1:0] rem_q, dvs_q;
  logic [3:0]     cnt_q;
  logic           done_q;
  logic [DvW:0]   trial, diff;
  logic           ge;

  assign trial  = {rem_q, quo_q[DdW-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign diff   = trial - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= Steps;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 4'd1;
        done_q <= (cnt_q == 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DvW-1:0] : trial[DvW-1:0];
      quo_q <= {quo_q[DdW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/lsfx_front.sv =====
// Front end: takes input transactions, classifies them by effect and strip length.
// Depends on lsfx_pkg and lsfx_fifo (command queue to the back end).
module lsfx_front import lsfx_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            restart_i,
  input  logic [2:0]      mode_i,
  input  logic [LenW-1:0] pixel_count_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output cmd_t            cmd_o,
  output logic            cmd_empty_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PIXELS);

  cmd_t cmd_in;
  cmd_t cmd_rd;

  always_comb begin
    cmd_in.restart = restart_i;
    if (pixel_count_i == '0) begin
      cmd_in.len = LenW'(1);
    end else if (pixel_count_i > MaxLen) begin
      cmd_in.len = MaxLen;
    end else begin
      cmd_in.len = pixel_count_i;
    end
    case (mode_i)
      MODE_OFF:   cmd_in.kind = K_BLACK;
      MODE_ALL:   cmd_in.kind = K_FORE;
      MODE_CHASE: cmd_in.kind = K_CHASE;
      MODE_FLASH: cmd_in.kind = K_FLASH;
      MODE_HEART: cmd_in.kind = K_HEART;
      MODE_TRAIL: cmd_in.kind = K_TRAIL;
      default:    cmd_in.kind = K_NONE;
    endcase
  end

  lsfx_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_rd;

endmodule

// ===== rtl/core/lsfx_back.sv =====
// Back end: sequencer that turns commands into pixel writes and keeps the step counter.
// Depends on lsfx_pkg and lsfx_div (shared modulo and dimming divider).
module lsfx_back import lsfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_empty_i,
  output logic        cmd_pop_o,
  input  logic [23:0] fore_i,
  input  logic [23:0] back_i,
  output res_t        res_o,
  output logic        res_push_o,
  input  logic        res_full_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_EMIT,
    S_DIVW,
    S_HB_CH,
    S_CH_MOD,
    S_CH_FG,
    S_TR_DIV,
    S_TR_EM,
    S_TR_MOD,
    S_TR_END
  } state_e;

  state_e          state_q, ret_q;
  logic [ScW-1:0]  sc_q, scw_q;
  logic [LenW-1:0] len_q;
  logic [IdxW-1:0] idx_q;
  logic [23:0]     col_q;
  logic            lv_q;
  logic [9:0]      lvl_q;
  res_t            res_q;
  logic [DdW-1:0]  acc_q;
  logic [2:0]      sub_q;
  logic [1:0]      chan_q;
  logic            div_start_q;
  logic [DdW-1:0]  div_a_q;
  logic [DvW-1:0]  div_b_q;

  logic            div_done;
  logic [DdW-1:0]  div_quot;
  logic [DvW-1:0]  div_rem;

  logic [ScW-1:0]  sc_e, sc_hb;
  logic [ScW:0]    hb_sum;
  logic [3:0]      hb_d;
  logic [7:0]      hb_gm;
  logic [LenW-1:0] nm1;
  logic            fill_last;
  res_t            fill_res;
  logic [23:0]     trail_col;

  lsfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign sc_e      = cmd_i.restart ? '0 : sc_q;
  assign hb_d      = heart_duty(sc_e);
  assign hb_gm     = GAMMA_LUT[hb_d];
  assign hb_sum    = {1'b0, sc_e} + HB_STEP;
  assign sc_hb     = (hb_sum >= {1'b0, DEG_FULL}) ? ScW'(hb_sum - {1'b0, DEG_FULL})
                                                  : hb_sum[ScW-1:0];
  assign nm1       = len_q - LenW'(1);
  assign fill_last = ({1'b0, idx_q} == nm1);

  always_comb begin
    fill_res.pixel_index = idx_q;
    fill_res.red         = col_q[23:16];
    fill_res.green       = col_q[15:8];
    fill_res.blue        = col_q[7:0];
    fill_res.led_valid   = lv_q && (idx_q == '0);
    fill_res.led_level   = (idx_q == '0) ? lvl_q : '0;
    fill_res.last        = fill_last;
  end

  always_comb begin
    if (sub_q == 3'd4) begin
      trail_col = back_i;
    end else begin
      trail_col = {fore_i[23:16] >> sub_q[1:0], fore_i[15:8] >> sub_q[1:0],
                   fore_i[7:0] >> sub_q[1:0]};
    end
  end

  assign res_push_o = !res_full_i && (state_q == S_FILL || state_q == S_EMIT);
  assign res_o      = (state_q == S_FILL) ? fill_res : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      sc_q        <= '0;
      scw_q       <= '0;
      len_q       <= LenW'(1);
      idx_q       <= '0;
      col_q       <= '0;
      lv_q        <= 1'b0;
      lvl_q       <= '0;
      res_q       <= '0;
      acc_q       <= '0;
      sub_q       <= '0;
      chan_q      <= '0;
      div_start_q <= 1'b0;
      div_a_q     <= '0;
      div_b_q     <= DvW'(1);
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            len_q <= cmd_i.len;
            idx_q <= '0;
            lv_q  <= 1'b0;
            lvl_q <= '0;
            case (cmd_i.kind)
              K_BLACK: begin
                col_q   <= '0;
                sc_q    <= sc_e;
                state_q <= S_FILL;
              end
              K_FORE: begin
                col_q   <= fore_i;
                sc_q    <= sc_e;
                state_q <= S_FILL;
              end
              K_FLASH: begin
                col_q   <= sc_e[0] ? fore_i : back_i;
                sc_q    <= sc_e + ScW'(1);
                state_q <= S_FILL;
              end
              K_HEART: begin
                sc_q <= sc_hb;
                if (hb_d != '0) begin
                  lv_q        <= 1'b1;
                  lvl_q       <= LVL_MAX - {hb_gm, 2'b00};
                  chan_q      <= '0;
                  div_a_q     <= {2'b00, fore_i[23:16]};
                  div_b_q     <= DIM_LUT[hb_d];
                  div_start_q <= 1'b1;
                  ret_q       <= S_HB_CH;
                  state_q     <= S_DIVW;
                end
              end
              K_CHASE: begin
                scw_q <= sc_e;
                if (sc_e < {2'b00, cmd_i.len}) begin
                  res_q.pixel_index <= sc_e[IdxW-1:0];
                  res_q.red         <= back_i[23:16];
                  res_q.green       <= back_i[15:8];
                  res_q.blue        <= back_i[7:0];
                  res_q.led_valid   <= 1'b0;
                  res_q.led_level   <= '0;
                  res_q.last        <= 1'b0;
                  ret_q             <= S_CH_MOD;
                  state_q           <= S_EMIT;
                end else begin
                  state_q <= S_CH_MOD;
                end
              end
              K_TRAIL: begin
                scw_q   <= sc_e;
                acc_q   <= {1'b0, sc_e};
                sub_q   <= '0;
                state_q <= S_TR_DIV;
              end
              default: begin
                sc_q <= sc_e;
              end
            endcase
          end
        end
        S_FILL: begin
          if (!res_full_i) begin
            if (fill_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        S_EMIT: begin
          if (!res_full_i) begin
            state_q <= ret_q;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            state_q <= ret_q;
          end
        end
        S_HB_CH: begin
          case (chan_q)
            2'd0: begin
              col_q[23:16] <= div_quot[7:0];
              div_a_q      <= {2'b00, fore_i[15:8]};
              div_start_q  <= 1'b1;
              chan_q       <= 2'd1;
              state_q      <= S_DIVW;
            end
            2'd1: begin
              col_q[15:8] <= div_quot[7:0];
              div_a_q     <= {2'b00, fore_i[7:0]};
              div_start_q <= 1'b1;
              chan_q      <= 2'd2;
              state_q     <= S_DIVW;
            end
            2'd2: begin
              col_q[7:0] <= div_quot[7:0];
              state_q    <= S_FILL;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_CH_MOD: begin
          div_a_q     <= {1'b0, scw_q} + DdW'(1);
          div_b_q     <= {1'b0, len_q};
          div_start_q <= 1'b1;
          ret_q       <= S_CH_FG;
          state_q     <= S_DIVW;
        end
        S_CH_FG: begin
          sc_q              <= {3'b000, div_rem[IdxW-1:0]};
          res_q.pixel_index <= div_rem[IdxW-1:0];
          res_q.red         <= fore_i[23:16];
          res_q.green       <= fore_i[15:8];
          res_q.blue        <= fore_i[7:0];
          res_q.led_valid   <= 1'b0;
          res_q.led_level   <= '0;
          res_q.last        <= 1'b1;
          ret_q             <= S_IDLE;
          state_q           <= S_EMIT;
        end
        S_TR_DIV: begin
          div_a_q     <= acc_q;
          div_b_q     <= {1'b0, len_q};
          div_start_q <= 1'b1;
          ret_q       <= S_TR_EM;
          state_q     <= S_DIVW;
        end
        S_TR_EM: begin
          res_q.pixel_index <= div_rem[IdxW-1:0];
          res_q.red         <= trail_col[23:16];
          res_q.green       <= trail_col[15:8];
          res_q.blue        <= trail_col[7:0];
          res_q.led_valid   <= 1'b0;
          res_q.led_level   <= '0;
          res_q.last        <= (sub_q == 3'd4);
          acc_q             <= acc_q + {3'b000, nm1};
          sub_q             <= sub_q + 3'd1;
          ret_q             <= (sub_q == 3'd4) ? S_TR_MOD : S_TR_DIV;
          state_q           <= S_EMIT;
        end
        S_TR_MOD: begin
          div_a_q     <= {1'b0, scw_q} + DdW'(1);
          div_b_q     <= {1'b0, len_q};
          div_start_q <= 1'b1;
          ret_q       <= S_TR_END;
          state_q     <= S_DIVW;
        end
        S_TR_END: begin
          sc_q    <= {3'b000, div_rem[IdxW-1:0]};
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/led_strip_effect_engine_top.sv =====
// LED strip effect engine top level: configuration registers, front end, back end
// and result queue. Depends on lsfx_pkg, lsfx_front, lsfx_back and lsfx_fifo.
// Chase, trail and heartbeat steps use the shared 10-step divider; the back end takes the next
// queued command only once the previous step is finished. Reset is asynchronous, clears control.
module led_strip_effect_engine_top import lsfx_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        restart_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        led_valid_o,
  output logic [9:0]  led_level_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [2:0]      mode_q;
  logic [LenW-1:0] pixels_q;
  logic [23:0]     fore_q, back_q;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      pixels_q <= LenW'(16);
      fore_q   <= '0;
      back_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[2:0];
        REG_PIXELS: pixels_q <= cfg_data_i[LenW-1:0];
        REG_FORE:   fore_q   <= cfg_data_i;
        REG_BACK:   back_q   <= cfg_data_i;
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  lsfx_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .restart_i     (restart_i),
    .mode_i        (mode_q),
    .pixel_count_i (pixels_q),
    .full_o        (full),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty)
  );

  lsfx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .fore_i      (fore_q),
    .back_i      (back_q),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  lsfx_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign pixel_index_o = res_out.pixel_index;
  assign red_o         = res_out.red;
  assign green_o       = res_out.green;
  assign blue_o        = res_out.blue;
  assign led_valid_o   = res_out.led_valid;
  assign led_level_o   = res_out.led_level;
  assign last_o        = res_out.last;

endmodule

// ===== rtl/core/lsfx_checker.sv =====
// Port-level checks of the LED strip effect engine, bound to the top level.
// Depends on led_strip_effect_engine_top port names only.
module lsfx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [5:0] pixel_index_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       led_valid_o,
  input logic [9:0] led_level_o,
  input logic       last_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pixel_index_o) && $stable(red_o)
      && $stable(green_o) && $stable(blue_o) && $stable(last_o))
    else $error("pending result transaction changed");

  a_led_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && led_valid_o |-> pixel_index_o == 6'd0)
    else $error("LED update not on first pixel");

  a_led_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !led_valid_o |-> led_level_o == 10'd0)
    else $error("LED level without LED update");

  a_led_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && led_valid_o |-> led_level_o[1:0] == 2'b11)
    else $error("LED level not 1023 minus four times gamma");

endmodule

bind led_strip_effect_engine_top lsfx_checker u_lsfx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .pixel_index_o (pixel_index_o),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .led_valid_o   (led_valid_o),
  .led_level_o   (led_level_o),
  .last_o        (last_o)
);

// ===== sim/tb_led_strip_effect_engine_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for led_strip_effect_engine_top: directed script, then random phases.
// Depends on lsfx_pkg and the RTL of the block; pixel writes are checked against a local model.
module tb_led_strip_effect_engine_top;
  import lsfx_pkg::*;

  localparam int          CLK_PERIOD    = 20;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          HOLD_CYCLES   = 600;
  localparam logic [2:0]  MODE_SPARE6   = 3'd6;
  localparam logic [2:0]  MODE_SPARE7   = 3'd7;

  localparam int unsigned SINE_EDGE [16] = '{
    0, 4, 8, 12, 16, 20, 24, 28, 33, 37, 42, 48, 54, 61, 69, 90
  };
  localparam int unsigned GAMMA_TAB [16] = '{
    0, 1, 2, 6, 12, 20, 31, 44, 60, 79, 100, 125, 153, 183, 218, 255
  };
  localparam logic [2:0] PHASE_MODES [9] = '{
    MODE_HEART, MODE_TRAIL, MODE_CHASE, MODE_ALL, MODE_FLASH,
    MODE_OFF, MODE_HEART, MODE_CHASE, MODE_TRAIL
  };

  typedef struct {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [23:0] data;
    logic        rs;
    logic        chk;
    res_t        want;
  } script_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        restart_i   = 1'b0;
  logic        pop         = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_MODE;
  logic [23:0] cfg_data_i  = '0;
  logic        full, empty, cfg_ready_o;
  logic [5:0]  pixel_index_o;
  logic [7:0]  red_o, green_o, blue_o;
  logic        led_valid_o, last_o;
  logic [9:0]  led_level_o;

  // typed expectation travels with the transaction it belongs to
  logic        chk_en  = 1'b0;
  res_t        chk_res = '0;

  // shadow of the block's registers and step counter
  logic [2:0]  fx_mode   = MODE_OFF;
  logic [6:0]  strip_cfg = 7'd16;
  logic [23:0] fore_rgb  = '0;
  logic [23:0] back_rgb  = '0;
  logic [8:0]  anim_step = '0;

  res_t        pixel_writes_q[$];
  script_row_t script_q[$];

  int          send_idle  = 28;
  int          recv_idle  = 85;
  logic        hold_go    = 1'b0;
  logic        hold_seen  = 1'b0;
  int          err_cnt    = 0;
  int          n_steps    = 0;
  int          n_writes   = 0;
  int          n_cfg      = 0;
  int          stall_cnt  = 0;

  led_strip_effect_engine_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .restart_i    (restart_i),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .pixel_index_o(pixel_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .led_valid_o  (led_valid_o),
    .led_level_o  (led_level_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic res_t pix(input int unsigned idx, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic lv, input logic [9:0] lvl,
                               input logic lst);
    res_t w;
    w.pixel_index = 6'(idx);
    w.red         = r;
    w.green       = g;
    w.blue        = b;
    w.led_valid   = lv;
    w.led_level   = lvl;
    w.last        = lst;
    return w;
  endfunction

  function automatic void put_px(input int unsigned idx, input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input logic lv, input logic [9:0] lvl,
                                 input logic lst);
    pixel_writes_q.push_back(pix(idx, r, g, b, lv, lvl, lst));
  endfunction

  function automatic int unsigned duty_of(input logic [8:0] deg);
    int unsigned a;
    int unsigned d;
    a = deg % 360;
    d = 0;
    if (a == 0 || a >= 180) return 0;
    if (a > 90) a = 180 - a;
    for (int k = 1; k < 16; k++) begin
      if (a >= SINE_EDGE[k]) d = k;
    end
    return d;
  endfunction

  // expected pixel writes of one animation step; advances the step counter but in off, all and spare modes
  function automatic void paint_step(input logic rs);
    int unsigned n;
    int unsigned d;
    int unsigned gm;
    int unsigned dv;
    logic [7:0]  fr, fg, fb, br, bg, bb;
    n = (strip_cfg == 0) ? 1 : (strip_cfg > 64) ? 64 : strip_cfg;
    {fr, fg, fb} = fore_rgb;
    {br, bg, bb} = back_rgb;
    if (rs) anim_step = '0;
    case (fx_mode)
      MODE_OFF: begin
        for (int k = 0; k < n; k++) put_px(k, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0, k == n - 1);
      end
      MODE_ALL: begin
        for (int k = 0; k < n; k++) put_px(k, fr, fg, fb, 1'b0, 10'd0, k == n - 1);
      end
      MODE_CHASE: begin
        if (anim_step < n) put_px(anim_step, br, bg, bb, 1'b0, 10'd0, 1'b0);
        anim_step = 9'((anim_step + 1) % n);
        put_px(anim_step, fr, fg, fb, 1'b0, 10'd0, 1'b1);
      end
      MODE_FLASH: begin
        for (int k = 0; k < n; k++) begin
          if (anim_step[0]) put_px(k, fr, fg, fb, 1'b0, 10'd0, k == n - 1);
          else put_px(k, br, bg, bb, 1'b0, 10'd0, k == n - 1);
        end
        anim_step = anim_step + 1'b1;
      end
      MODE_HEART: begin
        d = duty_of(anim_step);
        if (d > 0) begin
          gm = GAMMA_TAB[d];
          dv = 255 / gm;
          for (int k = 0; k < n; k++) begin
            put_px(k, 8'(fr / dv), 8'(fg / dv), 8'(fb / dv), k == 0,
                   (k == 0) ? 10'(1023 - 4 * gm) : 10'd0, k == n - 1);
          end
        end
        anim_step = 9'((anim_step + 10) % 360);
      end
      MODE_TRAIL: begin
        for (int k = 0; k < 4; k++) begin
          put_px((anim_step + k * (n - 1)) % n, fr >> k, fg >> k, fb >> k, 1'b0, 10'd0, 1'b0);
        end
        put_px((anim_step + 4 * (n - 1)) % n, br, bg, bb, 1'b0, 10'd0, 1'b1);
        anim_step = 9'((anim_step + 1) % n);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string fld, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
      err_cnt++;
    end
  endtask

  // transaction monitor and scoreboard
  always @(posedge clk_i) begin
    res_t        head;
    int unsigned base_n;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODE:   fx_mode   = cfg_data_i[2:0];
          REG_PIXELS: strip_cfg = cfg_data_i[6:0];
          REG_FORE:   fore_rgb  = cfg_data_i;
          REG_BACK:   back_rgb  = cfg_data_i;
          default: ;
        endcase
        n_cfg++;
      end
      if (pop && !empty) begin
        n_writes++;
        if (pixel_writes_q.size() == 0) begin
          $display("%0t: pixel write with nothing expected, expected none, got index %0d",
                   $time, pixel_index_o);
          err_cnt++;
        end else begin
          head = pixel_writes_q.pop_front();
          check_field("pixel_index", head.pixel_index, pixel_index_o);
          check_field("red", head.red, red_o);
          check_field("green", head.green, green_o);
          check_field("blue", head.blue, blue_o);
          check_field("led_valid", head.led_valid, led_valid_o);
          check_field("led_level", head.led_level, led_level_o);
          check_field("last", head.last, last_o);
        end
      end
      if (push && !full) begin
        base_n = pixel_writes_q.size();
        paint_step(restart_i);
        n_steps++;
        if (chk_en) begin
          if (pixel_writes_q.size() == base_n) begin
            $display("%0t: step check, expected %h, got no pixel write", $time, chk_res);
            err_cnt++;
          end else if (pixel_writes_q[base_n] != chk_res) begin
            $display("%0t: step check, expected %h, got %h", $time, chk_res,
                     pixel_writes_q[base_n]);
            err_cnt++;
          end
        end
      end
    end
  end

  // result side: random pop, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    while (stall_cnt < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL led_strip_effect_engine_top");
    $finish;
  end

  task automatic send_item(input logic rs, input logic chk, input res_t want);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    restart_i <= rs;
    chk_en    <= chk;
    chk_res   <= want;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // waits on the clock first so the monitor has booked the last accepted transaction
  task automatic drain_strip();
    push <= 1'b0;
    @(posedge clk_i);
    while (pixel_writes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_cfg(input logic [1:0] idx, input logic [23:0] data);
    script_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, rs: 1'b0, chk: 1'b0, want: '0};
    script_q.push_back(r);
  endfunction

  function automatic void add_step(input logic rs, input logic chk, input res_t want);
    script_row_t r;
    r = '{is_cfg: 1'b0, idx: REG_MODE, data: '0, rs: rs, chk: chk, want: want};
    script_q.push_back(r);
  endfunction

  initial begin
    logic       dirty;
    logic [2:0] mode;
    logic [6:0] px;
    int         pick;
    int         cnt;

    add_step(1'b0, 1'b1, pix(0, 8'h00, 8'h00, 8'h00, 1'b0, 10'd0, 1'b0));
    add_cfg(REG_PIXELS, 24'd1);
    add_step(1'b1, 1'b1, pix(0, 8'h00, 8'h00, 8'h00, 1'b0, 10'd0, 1'b1));
    add_cfg(REG_MODE, 24'(MODE_ALL));
    add_cfg(REG_FORE, 24'hFFFFFF);
    add_cfg(REG_PIXELS, 24'd64);
    add_step(1'b0, 1'b1, pix(0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 10'd0, 1'b0));
    // zero pixel count behaves as a one-pixel strip
    add_cfg(REG_PIXELS, 24'd0);
    add_step(1'b0, 1'b1, pix(0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 10'd0, 1'b1));
    add_cfg(REG_PIXELS, 24'd127);
    add_step(1'b1, 1'b0, '0);
    add_cfg(REG_MODE, 24'(MODE_CHASE));
    add_cfg(REG_PIXELS, 24'd8);
    add_cfg(REG_FORE, 24'h123456);
    add_cfg(REG_BACK, 24'hA5A5A5);
    add_step(1'b1, 1'b1, pix(0, 8'hA5, 8'hA5, 8'hA5, 1'b0, 10'd0, 1'b0));
    repeat (3) add_step(1'b0, 1'b0, '0);
    add_cfg(REG_MODE, 24'(MODE_FLASH));
    add_step(1'b1, 1'b1, pix(0, 8'hA5, 8'hA5, 8'hA5, 1'b0, 10'd0, 1'b0));
    add_step(1'b0, 1'b0, '0);
    // heartbeat: zero duty at 0 degrees, then first level update
    add_cfg(REG_MODE, 24'(MODE_HEART));
    add_cfg(REG_FORE, 24'hFFFFFF);
    add_step(1'b1, 1'b0, '0);
    add_step(1'b0, 1'b1, pix(0, 8'd2, 8'd2, 8'd2, 1'b1, 10'd1015, 1'b0));
    add_step(1'b0, 1'b0, '0);
    // chase counter beyond the strip: background write skipped
    add_cfg(REG_MODE, 24'(MODE_CHASE));
    add_cfg(REG_PIXELS, 24'd4);
    add_step(1'b0, 1'b1, pix(3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 10'd0, 1'b1));
    add_cfg(REG_MODE, 24'(MODE_TRAIL));
    add_cfg(REG_PIXELS, 24'd5);
    add_cfg(REG_BACK, 24'h000000);
    add_step(1'b0, 1'b0, '0);
    add_step(1'b1, 1'b0, '0);
    add_cfg(REG_MODE, 24'(MODE_SPARE6));
    add_step(1'b0, 1'b0, '0);
    add_cfg(REG_MODE, 24'(MODE_SPARE7));
    add_step(1'b1, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dirty = 1'b0;
    foreach (script_q[i]) begin
      if (script_q[i].is_cfg) begin
        if (dirty) drain_strip();
        dirty = 1'b0;
        write_reg(script_q[i].idx, script_q[i].data);
      end else begin
        cfg_valid_i <= 1'b0;
        send_item(script_q[i].rs, script_q[i].chk, script_q[i].want);
        dirty = 1'b1;
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle = 85;
        recv_idle = 28;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain_strip();
      mode = PHASE_MODES[ph];
      pick = $urandom_range(99);
      px   = (pick < 80) ? 7'($urandom_range(16, 1)) :
             (pick < 90) ? 7'd64 : 7'($urandom_range(127, 0));
      if (ph == 3) px = 7'd64;
      write_reg(REG_MODE, 24'(mode));
      write_reg(REG_PIXELS, 24'(px));
      write_reg(REG_FORE, (ph == 6) ? 24'hFFFFFF : 24'($urandom));
      write_reg(REG_BACK, 24'($urandom));
      cfg_valid_i <= 1'b0;
      // long receiver stall while the sender keeps offering
      if (ph == 3) hold_go <= ~hold_go;
      cnt = (mode == MODE_HEART) ? 20 : 8;
      repeat (cnt) send_item($urandom_range(9) == 0, 1'b0, '0);
    end

    drain_strip();
    if (pixel_writes_q.size() != 0) begin
      $display("%0t: expected %0d more pixel writes, got none", $time, pixel_writes_q.size());
      err_cnt++;
    end
    $display("Ran %0d animation steps across all effects and spare mode codes,", n_steps);
    $display("%0d pixel writes checked after %0d register writes, %0d errors",
             n_writes, n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS led_strip_effect_engine_top");
    end else begin
      $display("FAIL led_strip_effect_engine_top");
    end
    $finish;
  end

endmodule
